// File: rtl/cbpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cbpd_pkg;

   localparam logic [3:0] FMT_BITS_PAD     = 4'd0;
   localparam logic [3:0] FMT_BITS_PAD_REV = 4'd1;
   localparam logic [3:0] FMT_BITS         = 4'd2;
   localparam logic [3:0] FMT_BITS_REV     = 4'd3;
   localparam logic [3:0] FMT_BLOCK_MONO   = 4'd4;
   localparam logic [3:0] FMT_GREY2        = 4'd5;
   localparam logic [3:0] FMT_PAL16        = 4'd6;
   localparam logic [3:0] FMT_RGB4         = 4'd7;
   localparam logic [3:0] FMT_BLOCK_OGB    = 4'd8;
   localparam logic [3:0] FMT_PAL256       = 4'd9;
   localparam logic [3:0] FMT_RGB565       = 4'd10;
   localparam logic [3:0] FMT_MONO4        = 4'd11;

   localparam logic [1:0] CSR_FORMAT = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   localparam logic [23:0] RGB_BLACK  = 24'h000000;
   localparam logic [23:0] RGB_WHITE  = 24'hFFFFFF;
   localparam logic [23:0] RGB_LGREY  = 24'hAAAAAA;
   localparam logic [23:0] RGB_DGREY  = 24'h777777;
   localparam logic [23:0] RGB_ORANGE = 24'hFF8C00;
   localparam logic [23:0] RGB_AMBER  = 24'hFF8000;
   localparam logic [23:0] RGB_GREEN  = 24'h00FF00;
   localparam logic [23:0] RGB_BLUE   = 24'h0000FF;

   typedef enum logic [3:0] {
      CLS_ERROR,
      CLS_BITS,
      CLS_GREY,
      CLS_PAL16,
      CLS_RGB4,
      CLS_BLOCK,
      CLS_PAL256,
      CLS_RGB565,
      CLS_MONO
   } class_type;

   typedef struct packed {
      class_type  cls;
      logic       white;
      logic       padded;
      logic       three;
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] byte_c;
   } item_type;

   typedef struct packed {
      logic [23:0] rgb;
      logic [9:0]  x;
      logic [9:0]  y;
      logic        last;
      logic        done;
      logic        err;
   } result_type;

endpackage
`default_nettype wire

// File: rtl/calculator_bitmap_pixel_decoder_unit.sv
// Channel   Handshake         Payload
// req       push / full       byte_a, byte_b, byte_c
// rsp       empty / pop       pixel_rgb, pixel_x, pixel_y, last_of_item, picture_done,
//                             format_error
// csr       we                index, wdata (11 bits)
// The back end emits one pixel per cycle while the result queue has room: a 1-bit,
// grey or mono byte gives 1 to 8 pixels, a 4-bit byte 2, one-pixel formats 1, dropped 0.
// A four-deep request queue and a four-deep result queue let each side stall alone.
// Reset is synchronous; any register write restarts the picture.
`timescale 1ns / 1ps
`default_nettype none
module calculator_bitmap_pixel_decoder_unit
   import cbpd_pkg::*;
#(
   parameter int MAX_SIDE = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_byte_a,
   input  wire logic [7:0]  req_byte_b,
   input  wire logic [7:0]  req_byte_c,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [23:0]      rsp_pixel_rgb,
   output logic [9:0]       rsp_pixel_x,
   output logic [9:0]       rsp_pixel_y,
   output logic             rsp_last_of_item,
   output logic             rsp_picture_done,
   output logic             rsp_format_error,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_wdata
);
   localparam int SW = $clog2(MAX_SIDE + 1);

   logic [3:0]    fmt_ff;
   logic [10:0]   width_ff, height_ff;
   logic [SW-1:0] w, h;
   logic          restart, item_valid, item_pop, res_push, res_full;
   item_type      item;
   result_type    res, dout;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_BITS_PAD;
         width_ff  <= 11'd128;
         height_ff <= 11'd64;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FORMAT: fmt_ff    <= csr_wdata[3:0];
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   assign restart = csr_we && (csr_index == CSR_FORMAT || csr_index == CSR_WIDTH ||
                               csr_index == CSR_HEIGHT);

   // saturate to 1..MAX_SIDE
   assign w = (width_ff == 11'd0) ? SW'(1) :
              (32'(width_ff) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(width_ff);
   assign h = (height_ff == 11'd0) ? SW'(1) :
              (32'(height_ff) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(height_ff);

   cbpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .format     (fmt_ff),
      .push       (req_push),
      .full       (req_full),
      .byte_a     (req_byte_a),
      .byte_b     (req_byte_b),
      .byte_c     (req_byte_c),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   cbpd_back #(.SW(SW)) u_back (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .w          (w),
      .h          (h),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .res_push   (res_push),
      .res        (res),
      .res_full   (res_full)
   );

   cbpd_outq u_outq (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res),
      .full  (res_full),
      .empty (rsp_empty),
      .dout  (dout),
      .pop   (rsp_pop)
   );

   assign rsp_pixel_rgb    = dout.rgb;
   assign rsp_pixel_x      = dout.x;
   assign rsp_pixel_y      = dout.y;
   assign rsp_last_of_item = dout.last;
   assign rsp_picture_done = dout.done;
   assign rsp_format_error = dout.err;
endmodule
`default_nettype wire

// File: rtl/cbpd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cbpd_front
   import cbpd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [3:0] format,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] byte_a,
   input  wire logic [7:0] byte_b,
   input  wire logic [7:0] byte_c,
   output logic            item_valid,
   output item_type        item,
   input  wire logic       item_pop
);
   localparam int DEPTH = 4;

   item_type   mem_ff [DEPTH];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   item_type   cls_item;
   logic       do_push, do_pop;

   always_comb begin
      cls_item = '0;
      cls_item.byte_a = byte_a;
      cls_item.byte_b = byte_b;
      cls_item.byte_c = byte_c;
      case (format)
         FMT_BITS_PAD:     begin cls_item.cls = CLS_BITS; cls_item.padded = 1'b1; end
         FMT_BITS_PAD_REV: begin
            cls_item.cls = CLS_BITS; cls_item.padded = 1'b1; cls_item.white = 1'b1;
         end
         FMT_BITS:         cls_item.cls = CLS_BITS;
         FMT_BITS_REV:     begin cls_item.cls = CLS_BITS; cls_item.white = 1'b1; end
         FMT_BLOCK_MONO:   cls_item.cls = CLS_BLOCK;
         FMT_GREY2:        cls_item.cls = CLS_GREY;
         FMT_PAL16:        cls_item.cls = CLS_PAL16;
         FMT_RGB4:         cls_item.cls = CLS_RGB4;
         FMT_BLOCK_OGB:    begin cls_item.cls = CLS_BLOCK; cls_item.three = 1'b1; end
         FMT_PAL256:       cls_item.cls = CLS_PAL256;
         FMT_RGB565:       cls_item.cls = CLS_RGB565;
         FMT_MONO4:        cls_item.cls = CLS_MONO;
         default:          cls_item.cls = CLS_ERROR;
      endcase
   end

   assign full       = (cnt_ff == 3'(DEPTH));
   assign item_valid = (cnt_ff != 3'd0);
   assign item       = mem_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;
   assign wr_in      = do_push ? wr_ff + 2'd1 : wr_ff;
   assign rd_in      = do_pop ? rd_ff + 2'd1 : rd_ff;
   assign cnt_in     = cnt_ff + 3'(do_push) - 3'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= cls_item;
      end
   end
endmodule
`default_nettype wire

// File: rtl/cbpd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cbpd_back
   import cbpd_pkg::*;
#(
   parameter int SW = 11
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          restart,
   input  wire logic [SW-1:0] w,
   input  wire logic [SW-1:0] h,
   input  wire logic          item_valid,
   input  wire item_type      item,
   output logic               item_pop,
   output logic               res_push,
   output result_type         res,
   input  wire logic          res_full
);
   logic [SW-1:0]   col_ff, col_in, row_ff, row_in, bcol_ff, bcol_in;
   logic            fin_ff, fin_in;
   logic [2:0]      step_ff, step_in;
   logic [2*SW-1:0] skip_ff, skip_in, target_ff;
   logic [SW:0]     col1, row1, bcol1, nb, bx, bxi;
   logic [2:0]      bidx, nlast;
   logic [3:0]      nib;
   logic            emit, drop, go, last, backward, row_end, fin_now, bit_a;
   logic [23:0]     rgb;
   logic [SW-1:0]   x, y;

   assign bidx  = ~step_ff;
   assign bit_a = item.byte_a[bidx];
   assign nib   = step_ff[0] ? item.byte_a[3:0] : item.byte_a[7:4];
   assign col1  = {1'b0, col_ff} + 1'b1;
   assign row1  = {1'b0, row_ff} + 1'b1;
   assign bcol1 = {1'b0, bcol_ff} + 1'b1;
   assign nb    = ({1'b0, w} + (SW+1)'(7)) >> 3;
   assign bx    = (nb - 1'b1 - {1'b0, bcol_ff}) << 3;
   assign bxi   = bx + (SW+1)'(step_ff);

   always_comb begin
      rgb = RGB_BLACK;
      backward = 1'b0;
      nlast = 3'd7;
      case (item.cls)
         CLS_BITS, CLS_MONO: rgb = (bit_a != item.white) ? RGB_BLACK : RGB_WHITE;
         CLS_GREY: begin
            case ({bit_a, item.byte_b[bidx]})
               2'b00:   rgb = RGB_WHITE;
               2'b01:   rgb = RGB_LGREY;
               2'b10:   rgb = RGB_DGREY;
               default: rgb = RGB_BLACK;
            endcase
         end
         CLS_PAL16: begin
            nlast = 3'd1;
            rgb = nib[3] ? RGB_BLACK : {{8{nib[2]}}, {8{nib[1]}}, {8{nib[0]}}};
         end
         CLS_RGB4: begin
            nlast = 3'd1;
            backward = 1'b1;
            rgb = {{8{nib[3]}}, {8{nib[2]}}, {8{nib[1]}}};
         end
         CLS_PAL256: begin
            nlast = 3'd0;
            case (item.byte_a)
               8'd0:    rgb = RGB_WHITE;
               8'd1:    rgb = RGB_AMBER;
               8'd2:    rgb = RGB_GREEN;
               8'd3:    rgb = RGB_BLUE;
               default: rgb = RGB_BLACK;
            endcase
         end
         CLS_RGB565: begin
            nlast = 3'd0;
            rgb = {item.byte_a[7:3], 3'b0, item.byte_a[2:0], item.byte_b[7:5], 2'b0,
                   item.byte_b[4:0], 3'b0};
         end
         CLS_BLOCK: begin
            if (!item.three) rgb = bit_a ? RGB_BLACK : RGB_WHITE;
            else if (bit_a) rgb = RGB_ORANGE;
            else if (item.byte_b[bidx]) rgb = RGB_GREEN;
            else if (item.byte_c[bidx]) rgb = RGB_BLUE;
            else rgb = RGB_WHITE;
         end
         default: rgb = RGB_BLACK;
      endcase
   end

   // per-cycle sequencer: one pixel, or one dropped item
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      bcol_in = bcol_ff;
      fin_in  = fin_ff;
      skip_in = skip_ff;
      step_in = step_ff;
      emit = 1'b0;
      drop = 1'b0;
      last = 1'b0;
      row_end = 1'b0;
      fin_now = 1'b0;
      x = col_ff;
      y = row_ff;
      res = '0;
      if (item.cls == CLS_ERROR) begin
         emit = 1'b1;
         last = 1'b1;
         res.last = 1'b1;
         res.err = 1'b1;
      end else if (fin_ff) begin
         drop = 1'b1;
      end else if (item.cls == CLS_MONO && skip_ff < target_ff) begin
         drop = 1'b1;
         skip_in = skip_ff + 1'b1;
      end else if (item.cls == CLS_BLOCK) begin
         emit = 1'b1;
         x = SW'(bxi);
         y = h - 1'b1 - row_ff;
         last = (step_ff == 3'd7) || (bxi + 1'b1 >= {1'b0, w});
         if (last) begin
            if (row1 >= {1'b0, h}) begin
               row_in = '0;
               bcol_in = SW'(bcol1);
               fin_now = (bcol1 >= nb);
            end else begin
               row_in = SW'(row1);
            end
         end
         res.rgb = rgb;
      end else begin
         emit = 1'b1;
         if (backward) begin
            x = w - 1'b1 - col_ff;
            y = h - 1'b1 - row_ff;
         end
         row_end = (col1 >= {1'b0, w});
         if (row_end) begin
            col_in = '0;
            row_in = SW'(row1);
            fin_now = (row1 >= {1'b0, h});
         end else begin
            col_in = SW'(col1);
         end
         last = (step_ff == nlast) || fin_now || (item.padded && row_end);
         res.rgb = rgb;
      end
      if (item.cls != CLS_ERROR) begin
         res.x = 10'(x);
         res.y = 10'(y);
         res.last = last;
         res.done = fin_now;
      end
      if (fin_now) fin_in = 1'b1;
      if (drop || last) step_in = '0;
      else step_in = step_ff + 3'd1;
   end

   assign go       = item_valid && (drop || (emit && !res_full));
   assign res_push = item_valid && emit && !res_full;
   assign item_pop = go && (drop || last);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff  <= '0;
         row_ff  <= '0;
         bcol_ff <= '0;
         fin_ff  <= 1'b0;
         skip_ff <= '0;
         step_ff <= '0;
      end else if (go) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         bcol_ff <= bcol_in;
         fin_ff  <= fin_in;
         skip_ff <= skip_in;
         step_ff <= step_in;
      end
   end

   // bytes to skip in the 4-bit mono format: w*h rounded down to even
   always_ff @(posedge clock) begin
      target_ff <= (w * h) & ~(2*SW)'(1);
   end
endmodule
`default_nettype wire

// File: rtl/cbpd_outq.sv
`timescale 1ns / 1ps
`default_nettype none
module cbpd_outq
   import cbpd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type din,
   output logic            full,
   output logic            empty,
   output result_type      dout,
   input  wire logic       pop
);
   localparam int DEPTH = 4;

   result_type mem_ff [DEPTH];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 3'(DEPTH));
   assign empty   = (cnt_ff == 3'd0);
   assign dout    = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_ff + 2'(do_push);
         rd_ff  <= rd_ff + 2'(do_pop);
         cnt_ff <= cnt_ff + 3'(do_push) - 3'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= din;
      end
   end
endmodule
`default_nettype wire

// File: tb/sv/calculator_bitmap_pixel_decoder_unit_test.sv
`timescale 1ns / 1ps
module calculator_bitmap_pixel_decoder_unit_test;
   import cbpd_pkg::*;

   localparam int SIDE_MAX = 1024;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_byte_a = 8'd0;
   logic [7:0]  req_byte_b = 8'd0;
   logic [7:0]  req_byte_c = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [23:0] rsp_pixel_rgb;
   logic [9:0]  rsp_pixel_x;
   logic [9:0]  rsp_pixel_y;
   logic        rsp_last_of_item;
   logic        rsp_picture_done;
   logic        rsp_format_error;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_FORMAT;
   logic [10:0] csr_wdata = 11'd0;

   calculator_bitmap_pixel_decoder_unit #(.MAX_SIDE(SIDE_MAX)) dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // decoder shadow state
   logic [3:0]  fmt_q;
   logic [10:0] width_q, height_q;
   int unsigned col_q, row_q, bcol_q, skip_q;
   bit          finished_q;

   result_type  pixel_q[$];
   result_type  step_q[$];

   int  mismatch_count = 0;
   int  item_count = 0;
   int  pixel_count = 0;
   int  error_count = 0;
   int  done_count = 0;
   bit  idle_on = 1'b1;
   int  hold_left = 0;

   function automatic int unsigned side(logic [10:0] v);
      if (v < 1) return 1;
      if (v > SIDE_MAX) return SIDE_MAX;
      return v;
   endfunction

   task automatic restart_picture();
      col_q = 0;
      row_q = 0;
      bcol_q = 0;
      finished_q = 1'b0;
      skip_q = (side(height_q) * side(width_q) / 2) * 2;
   endtask

   task automatic emit(logic [23:0] rgb, int unsigned x, int unsigned y);
      result_type r;
      r = '0;
      r.rgb = rgb;
      r.x = x[9:0];
      r.y = y[9:0];
      step_q.push_back(r);
   endtask

   task automatic raster(logic [23:0] rgb, bit backward, output bit row_end);
      int unsigned w, h, x, y;
      w = side(width_q);
      h = side(height_q);
      x = col_q;
      y = row_q;
      row_end = 1'b0;
      if (finished_q) begin
         row_end = 1'b1;
         return;
      end
      if (backward) begin
         x = w - 1 - x;
         y = h - 1 - y;
      end
      emit(rgb, x, y);
      col_q++;
      if (col_q >= w) begin
         col_q = 0;
         row_q++;
         if (row_q >= h) begin
            finished_q = 1'b1;
            step_q[$].done = 1'b1;
         end
         row_end = 1'b1;
      end
   endtask

   task automatic raster_bits(logic [7:0] b, bit set_white, bit padded);
      bit re;
      for (int i = 7; i >= 0; i--) begin
         if (finished_q) break;
         raster(((b[i] != set_white) ? RGB_BLACK : RGB_WHITE), 1'b0, re);
         if (re && padded) break;
      end
   endtask

   task automatic column_block(logic [7:0] a, logic [7:0] b, logic [7:0] c, bit three);
      int unsigned w, h, nb, bx, y;
      logic [23:0] rgb;
      w = side(width_q);
      h = side(height_q);
      nb = (w + 7) / 8;
      bx = 8 * (nb - 1 - bcol_q);
      y = h - 1 - row_q;
      for (int i = 0; i < 8; i++) begin
         if (bx + i >= w) continue;
         if (three) begin
            if (a[7-i]) rgb = RGB_ORANGE;
            else if (b[7-i]) rgb = RGB_GREEN;
            else if (c[7-i]) rgb = RGB_BLUE;
            else rgb = RGB_WHITE;
         end else begin
            rgb = a[7-i] ? RGB_BLACK : RGB_WHITE;
         end
         emit(rgb, bx + i, y);
      end
      row_q++;
      if (row_q >= h) begin
         row_q = 0;
         bcol_q++;
         if (bcol_q >= nb) begin
            finished_q = 1'b1;
            if (step_q.size() > 0) step_q[$].done = 1'b1;
         end
      end
   endtask

   function automatic logic [23:0] rgb_nibble(logic [3:0] n);
      return {{8{n[3]}}, {8{n[2]}}, {8{n[1]}}};
   endfunction

   function automatic logic [23:0] pal16_color(logic [3:0] n);
      if (n[3]) return RGB_BLACK;
      return {{8{n[2]}}, {8{n[1]}}, {8{n[0]}}};
   endfunction

   // expected pixels for one accepted request
   task automatic decode_request(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      bit re;
      logic [1:0] g;
      logic [23:0] px;
      result_type r;
      step_q.delete();
      if (fmt_q > FMT_MONO4) begin
         r = '0;
         r.last = 1'b1;
         r.err = 1'b1;
         pixel_q.push_back(r);
         return;
      end
      if (finished_q) return;
      case (fmt_q)
         FMT_BITS_PAD:     raster_bits(a, 1'b0, 1'b1);
         FMT_BITS_PAD_REV: raster_bits(a, 1'b1, 1'b1);
         FMT_BITS:         raster_bits(a, 1'b0, 1'b0);
         FMT_BITS_REV:     raster_bits(a, 1'b1, 1'b0);
         FMT_BLOCK_MONO:   column_block(a, b, c, 1'b0);
         FMT_GREY2: begin
            for (int i = 7; i >= 0; i--) begin
               if (finished_q) break;
               g = {a[i], b[i]};
               case (g)
                  2'd0: px = RGB_WHITE;
                  2'd1: px = RGB_LGREY;
                  2'd2: px = RGB_DGREY;
                  default: px = RGB_BLACK;
               endcase
               raster(px, 1'b0, re);
            end
         end
         FMT_PAL16: begin
            raster(pal16_color(a[7:4]), 1'b0, re);
            raster(pal16_color(a[3:0]), 1'b0, re);
         end
         FMT_RGB4: begin
            raster(rgb_nibble(a[7:4]), 1'b1, re);
            raster(rgb_nibble(a[3:0]), 1'b1, re);
         end
         FMT_BLOCK_OGB: column_block(a, b, c, 1'b1);
         FMT_PAL256: begin
            case (a)
               8'd0: px = RGB_WHITE;
               8'd1: px = RGB_AMBER;
               8'd2: px = RGB_GREEN;
               8'd3: px = RGB_BLUE;
               default: px = RGB_BLACK;
            endcase
            raster(px, 1'b0, re);
         end
         FMT_RGB565: raster({a[7:3], 3'b000, a[2:0], b[7:5], 2'b00, b[4:0], 3'b000},
                            1'b0, re);
         default: begin
            if (skip_q > 0) begin
               skip_q--;
               return;
            end
            raster_bits(a, 1'b0, 1'b0);
         end
      endcase
      if (step_q.size() > 0) step_q[$].last = 1'b1;
      foreach (step_q[i]) pixel_q.push_back(step_q[i]);
   endtask

   // ---------------- request side ----------------
   task automatic send_request(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      req_push <= 1'b1;
      req_byte_a <= a;
      req_byte_b <= b;
      req_byte_c <= c;
      do @(posedge clock); while (req_full);
      decode_request(a, b, c);
      item_count++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic send_random(int n);
      repeat (n) send_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      // dropped requests may still be in flight
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [10:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FORMAT: fmt_q = value[3:0];
         CSR_WIDTH:  width_q = value;
         CSR_HEIGHT: height_q = value;
         default: return;
      endcase
      restart_picture();
   endtask

   task automatic setup_picture(logic [3:0] f, logic [10:0] w, logic [10:0] h);
      write_csr(CSR_FORMAT, {7'($urandom_range(0, 127)), f});
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_HEIGHT, h);
   endtask

   // ---------------- result side ----------------
   initial begin
      int stall_left;
      result_type e;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (pixel_q.size() == 0) begin
               $display("%0t: unexpected pixel rgb=%h x=%0d y=%0d", $time, rsp_pixel_rgb,
                        rsp_pixel_x, rsp_pixel_y);
               mismatch_count++;
            end else begin
               e = pixel_q.pop_front();
               pixel_count++;
               if (e.err) error_count++;
               if (e.done) done_count++;
               if (rsp_pixel_rgb !== e.rgb || rsp_pixel_x !== e.x || rsp_pixel_y !== e.y ||
                   rsp_last_of_item !== e.last || rsp_picture_done !== e.done ||
                   rsp_format_error !== e.err) begin
                  $display("%0t: expected rgb=%h x=%0d y=%0d last=%b done=%b err=%b",
                           $time, e.rgb, e.x, e.y, e.last, e.done, e.err);
                  $display("%0t: actual   rgb=%h x=%0d y=%0d last=%b done=%b err=%b",
                           $time, rsp_pixel_rgb, rsp_pixel_x, rsp_pixel_y,
                           rsp_last_of_item, rsp_picture_done, rsp_format_error);
                  mismatch_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_reset_defaults();
      // 128x64 row-padded mono straight out of reset
      send_request(8'h00, 8'hFF, 8'h00);
      send_request(8'hFF, 8'h00, 8'hFF);
      send_request(8'hA5, 8'h5A, 8'h3C);
   endtask

   task automatic test_each_format();
      for (int f = 0; f < 12; f++) begin
         setup_picture(f[3:0], 11'd5, 11'd3);
         send_request(8'h00, 8'h00, 8'h00);
         send_request(8'hFF, 8'hFF, 8'hFF);
         send_request(8'h5A, 8'hC3, 8'h96);
      end
   endtask

   task automatic test_unknown_formats();
      for (int f = 12; f < 16; f++) begin
         write_csr(CSR_FORMAT, 11'(f));
         send_request(8'hFF, 8'hFF, 8'hFF);
      end
      write_csr(CSR_UNUSED, 11'h7FF);
   endtask

   task automatic test_size_extremes();
      // zero and oversize sides saturate
      setup_picture(FMT_BITS, 11'd0, 11'd0);
      send_request(8'h80, 8'h00, 8'h00);
      send_request(8'hFF, 8'h00, 8'h00);
      setup_picture(FMT_RGB565, 11'h7FF, 11'h7FF);
      send_request(8'hFF, 8'h00, 8'h00);
      send_request(8'h07, 8'hE0, 8'h1F);
      setup_picture(FMT_BITS_PAD, 11'd1024, 11'd1024);
      send_request(8'h81, 8'h00, 8'h00);
      // widths not a multiple of eight for column blocks, including a width below one block
      setup_picture(FMT_BLOCK_OGB, 11'd3, 11'd2);
      send_random(4);
      setup_picture(FMT_BLOCK_MONO, 11'd10, 11'd1);
      send_random(4);
   endtask

   task automatic test_mono_skip();
      setup_picture(FMT_MONO4, 11'd3, 11'd3);
      send_random(8);
      setup_picture(FMT_MONO4, 11'd1, 11'd1);
      send_random(3);
   endtask

   task automatic test_backpressure();
      setup_picture(FMT_BITS, 11'd64, 11'd64);
      hold_left = 300;
      send_random(40);
      wait_drained();
      send_random(10);
   endtask

   task automatic test_random_pictures(int phases);
      int unsigned f, w, h, n, pix;
      for (int p = 0; p < phases; p++) begin
         f = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11);
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
         if (f == FMT_BLOCK_MONO || f == FMT_BLOCK_OGB) w = 8 * $urandom_range(1, 3);
         setup_picture(f[3:0], w[10:0], h[10:0]);
         // bytes to finish the picture, at times halved and capped at 40, plus up to three more
         pix = w * h;
         case (f)
            FMT_PAL256, FMT_RGB565:     n = pix;
            FMT_PAL16, FMT_RGB4:        n = (pix + 1) / 2;
            FMT_BLOCK_MONO, FMT_BLOCK_OGB: n = h * ((w + 7) / 8);
            FMT_MONO4:                  n = (pix + 7) / 8 + (pix / 2) * 2;
            FMT_BITS_PAD, FMT_BITS_PAD_REV: n = h * ((w + 7) / 8);
            default:                    n = (pix + 7) / 8;
         endcase
         if ($urandom_range(0, 4) == 0) n = n / 2;
         if (n > 40) n = 40;
         n += $urandom_range(0, 3);
         send_random(n);
      end
   endtask

   initial begin
      fmt_q = FMT_BITS_PAD;
      width_q = 11'd128;
      height_q = 11'd64;
      restart_picture();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_each_format();
      test_unknown_formats();
      test_size_extremes();
      test_mono_skip();
      test_backpressure();
      test_random_pictures(18);
      idle_on = 1'b0;
      test_random_pictures(4);
      wait_drained();
      $display("Sent %0d requests over all 16 format codes; checked %0d pixels,", item_count,
               pixel_count);
      $display("%0d format errors and %0d completed pictures.", error_count, done_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
rtl/cbpd_pkg.sv
rtl/cbpd_front.sv
rtl/cbpd_back.sv
rtl/cbpd_outq.sv
rtl/calculator_bitmap_pixel_decoder_unit.sv
tb/sv/calculator_bitmap_pixel_decoder_unit_test.sv
